FILE: design/sqvs_pkg.sv
// Package for the sprite quad vertex setup block.
// Holds the queue item type, fixed-point constants and helper functions.
// No dependencies.
package sqvs_pkg;

   // Divider operand widths
   localparam int NUM_W = 48;
   localparam int DEN_W = 23;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   // Configuration register indexes
   localparam logic [1:0] REG_VP_W  = 2'd0;
   localparam logic [1:0] REG_VP_H  = 2'd1;
   localparam logic [1:0] REG_TEX_W = 2'd2;
   localparam logic [1:0] REG_TEX_H = 2'd3;

   // One classified sprite waiting for the back end
   typedef struct packed {
      logic signed [25:0] cx9;
      logic signed [25:0] cy9;
      logic signed [23:0] dw;
      logic signed [23:0] dh;
      logic [31:0]        rgba;
      logic [15:0]        angle;
      logic signed [24:0] u_lo;
      logic signed [24:0] u_hi;
      logic signed [24:0] v_lo;
      logic signed [24:0] v_hi;
   } sqvs_item_type;

   // Quarter-wave sine entry in Q1.15 from an angle in Q30 radians
   function automatic logic [15:0] sine_from_theta(input longint unsigned theta);
      longint unsigned t2;
      longint unsigned term;
      longint          sum;
      longint          r;
      t2   = (theta * theta) >> 30;
      term = theta;
      sum  = longint'(theta);
      term = ((term * t2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 156; sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 210; sum = sum - longint'(term);
      if (sum < 0) sum = 0;
      r = (sum + 16384) >>> 15;
      if (r > 32768) r = 32768;
      return r[15:0];
   endfunction

   // Vertex slot to corner: TL, TR, BL, BL, TR, BR
   function automatic logic [1:0] corner_of(input logic [2:0] slot);
      logic [1:0] c;
      case (slot)
         3'd0: c = 2'd0;
         3'd1: c = 2'd1;
         3'd2: c = 2'd2;
         3'd3: c = 2'd2;
         3'd4: c = 2'd1;
         default: c = 2'd3;
      endcase
      return c;
   endfunction

   // Saturate to signed Q3.16
   function automatic logic [19:0] sat20(input logic signed [48:0] v);
      logic [19:0] r;
      if (v < -49'sd524288)      r = 20'h80000;
      else if (v > 49'sd524287)  r = 20'h7FFFF;
      else                       r = v[19:0];
      return r;
   endfunction

endpackage

FILE: design/sqvs_if.sv
// Channel interfaces for the sprite quad vertex setup block.
// Depends on nothing; carries sprite requests and vertex results.
interface sqvs_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] dest_left;
   logic signed [23:0] dest_top;
   logic signed [23:0] dest_width;
   logic signed [23:0] dest_height;
   logic [31:0]        rgba;
   logic [15:0]        turn_angle;
   logic signed [23:0] src_left;
   logic signed [23:0] src_top;
   logic signed [23:0] src_width;
   logic signed [23:0] src_height;

   modport source (output valid, dest_left, dest_top, dest_width, dest_height, rgba,
                   turn_angle, src_left, src_top, src_width, src_height, input ready);
   modport sink   (input valid, dest_left, dest_top, dest_width, dest_height, rgba,
                   turn_angle, src_left, src_top, src_width, src_height, output ready);
endinterface

interface sqvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] ndc_x;
   logic signed [19:0] ndc_y;
   logic [31:0]        vertex_color;
   logic signed [19:0] tex_u;
   logic signed [19:0] tex_v;
   logic [1:0]         corner_id;
   logic               last_vertex;

   modport source (output valid, ndc_x, ndc_y, vertex_color, tex_u, tex_v, corner_id,
                   last_vertex, input ready);
   modport sink   (input valid, ndc_x, ndc_y, vertex_color, tex_u, tex_v, corner_id,
                   last_vertex, output ready);
endinterface

FILE: design/sqvs_fifo.sv
// Two-entry queue between the front and back ends.
// Depends on sqvs_pkg for the item type.
module sqvs_fifo
   import sqvs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sqvs_item_type push_data,
   output logic          full,
   input  logic          pop,
   output sqvs_item_type pop_data,
   output logic          empty
);

   sqvs_item_type mem_ff [0:1];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: design/sqvs_front.sv
// Front end: takes sprite requests, forms centers and source edges.
// Depends on sqvs_pkg and sqvs_req_if; feeds sqvs_fifo.
module sqvs_front
   import sqvs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sqvs_req_if.sink      req_ch,
   output logic          push,
   output sqvs_item_type push_data,
   input  logic          full
);

   logic          valid_ff, valid_in;
   sqvs_item_type item_ff, item_in;
   logic          take;

   assign req_ch.ready = !valid_ff || !full;
   assign take         = req_ch.valid && req_ch.ready;
   assign push         = valid_ff && !full;
   assign push_data    = item_ff;

   // doubled centers and source edge positions
   always_comb begin
      item_in.cx9   = 26'(2 * 26'(req_ch.dest_left)) + 26'(req_ch.dest_width);
      item_in.cy9   = 26'(2 * 26'(req_ch.dest_top)) + 26'(req_ch.dest_height);
      item_in.dw    = req_ch.dest_width;
      item_in.dh    = req_ch.dest_height;
      item_in.rgba  = req_ch.rgba;
      item_in.angle = req_ch.turn_angle;
      item_in.u_lo  = 25'(req_ch.src_left);
      item_in.u_hi  = 25'(req_ch.src_left) + 25'(req_ch.src_width);
      item_in.v_lo  = 25'(req_ch.src_top);
      item_in.v_hi  = 25'(req_ch.src_top) + 25'(req_ch.src_height);
      valid_in      = take || (valid_ff && full);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) item_ff <= item_in;
   end

endmodule

FILE: design/sqvs_div.sv
// Restoring divider, one quotient bit per cycle, floor rounding.
// Depends on sqvs_pkg for operand widths.
module sqvs_div
   import sqvs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output logic signed [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic             fits;

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

   // one shift-subtract step; negative dividends take the ceiling of the magnitude
   always_comb begin
      rem_sh  = {rem_ff[DEN_W-1:0], mag_ff[NUM_W-1]};
      fits    = (rem_sh >= {1'b0, den_ff});
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in  = num[NUM_W-1];
         mag_in  = num[NUM_W-1] ? NUM_W'(-num) + NUM_W'(den) - NUM_W'(1) : NUM_W'(num);
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         mag_in = {mag_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

endmodule

FILE: design/sqvs_back.sv
// Back end: sine lookup, corner rotation, twelve divisions, six vertex transfers.
// Depends on sqvs_pkg, sqvs_div and sqvs_rsp_if.
module sqvs_back
   import sqvs_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   output logic          pop,
   input  sqvs_item_type pop_data,
   input  logic [13:0]   vp_w,
   input  logic [13:0]   vp_h,
   input  logic [14:0]   tex_w,
   input  logic [14:0]   tex_h,
   sqvs_rsp_if.source    rsp_ch
);

   localparam int N  = SINE_TABLE_ENTRIES;
   localparam int IW = $clog2(N + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SIN  = 3'd1;
   localparam logic [2:0] ST_COS  = 3'd2;
   localparam logic [2:0] ST_CAP  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_WAIT = 3'd6;
   localparam logic [2:0] ST_EMIT = 3'd7;

   // quarter-wave table
   logic [15:0] rom [0:N];
   for (genvar g = 0; g <= N; g++) begin : g_rom
      localparam longint unsigned THETA = (longint'(g) * PI_HALF_Q30) / SINE_TABLE_ENTRIES;
      assign rom[g] = sine_from_theta(THETA);
   end

   logic [2:0]          state_ff, state_in;
   sqvs_item_type       item_ff;
   logic [IW-1:0]       rom_addr;
   logic [15:0]         rom_q_ff;
   logic signed [16:0]  sin_ff, cos_ff;
   logic signed [40:0]  p1_ff, p2_ff, p3_ff, p4_ff;
   logic [3:0]          job_ff, job_in;
   logic [2:0]          slot_ff, slot_in;
   logic [19:0]         nx_ff [0:3];
   logic [19:0]         ny_ff [0:3];
   logic [19:0]         u_ff  [0:1];
   logic [19:0]         v_ff  [0:1];

   // table index from the angle remainder
   logic [1:0]    quad;
   logic [31:0]   idx_full;
   logic [IW-1:0] idx;
   logic [IW-1:0] sin_addr, cos_addr;
   logic          sin_neg, cos_neg;

   always_comb begin
      quad     = item_ff.angle[15:14];
      idx_full = ((32'(item_ff.angle[13:0]) * 32'(N)) + 32'd8192) >> 14;
      idx      = (idx_full > 32'(N)) ? IW'(N) : idx_full[IW-1:0];
      sin_addr = quad[0] ? IW'(N) - idx : idx;
      cos_addr = quad[0] ? idx : IW'(N) - idx;
      sin_neg  = quad[1];
      cos_neg  = quad[1] ^ quad[0];
      rom_addr = (state_ff == ST_COS) ? cos_addr : sin_addr;
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= rom[rom_addr];
   end

   // divider operands for the current job
   logic signed [NUM_W-1:0] cx_s, cy_s, acc, div_num, div_quot;
   logic [DEN_W-1:0]        div_den;
   logic                    div_done;
   logic [1:0]              k;
   logic [1:0]              grp;
   logic signed [24:0]      uv;
   logic [13:0]             vpd_w, vpd_h;
   logic [14:0]             txd_w, txd_h;

   always_comb begin
      vpd_w = (vp_w == 14'd0) ? 14'd1 : vp_w;
      vpd_h = (vp_h == 14'd0) ? 14'd1 : vp_h;
      txd_w = (tex_w == 15'd0) ? 15'd1 : tex_w;
      txd_h = (tex_h == 15'd0) ? 15'd1 : tex_h;
      k     = job_ff[1:0];
      grp   = job_ff[3:2];
      cx_s  = NUM_W'(item_ff.cx9) <<< 15;
      cy_s  = NUM_W'(item_ff.cy9) <<< 15;
      uv    = '0;
      acc   = '0;
      div_num = '0;
      div_den = '0;
      case (grp)
         2'd0: begin
            acc = cx_s + (k[0] ? NUM_W'(p1_ff) : -NUM_W'(p1_ff))
                       - (k[1] ? NUM_W'(p2_ff) : -NUM_W'(p2_ff));
            div_num = (acc <<< 1) + NUM_W'({vpd_w, 7'd0});
            div_den = DEN_W'({vpd_w, 8'd0});
         end
         2'd1: begin
            acc = cy_s + (k[0] ? NUM_W'(p3_ff) : -NUM_W'(p3_ff))
                       + (k[1] ? NUM_W'(p4_ff) : -NUM_W'(p4_ff));
            div_num = (acc <<< 1) + NUM_W'({vpd_h, 7'd0});
            div_den = DEN_W'({vpd_h, 8'd0});
         end
         default: begin
            // last four jobs: u low/high, then v low/high
            if (!k[1]) begin
               uv      = k[0] ? item_ff.u_hi : item_ff.u_lo;
               div_num = (NUM_W'(uv) <<< 9) + NUM_W'(txd_w);
               div_den = DEN_W'({txd_w, 1'b0});
            end else begin
               uv      = k[0] ? item_ff.v_hi : item_ff.v_lo;
               div_num = (NUM_W'(uv) <<< 9) + NUM_W'(txd_h);
               div_den = DEN_W'({txd_h, 1'b0});
            end
         end
      endcase
   end

   sqvs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DIV),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      slot_in  = slot_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               state_in = ST_SIN;
            end
         end
         ST_SIN:  state_in = ST_COS;
         ST_COS:  state_in = ST_CAP;
         ST_CAP:  state_in = ST_MUL;
         ST_MUL: begin
            job_in   = 4'd0;
            state_in = ST_DIV;
         end
         ST_DIV:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) begin
               if (job_ff == 4'd11) begin
                  slot_in  = 3'd0;
                  state_in = ST_EMIT;
               end else begin
                  job_in   = job_ff + 4'd1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               if (slot_ff == 3'd5) state_in = ST_IDLE;
               else                 slot_in  = slot_ff + 3'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= 4'd0;
         slot_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         slot_ff  <= slot_in;
      end
   end

   // payload: sine/cosine, products and saturated quotients
   logic signed [48:0] q_ext;
   assign q_ext = 49'(div_quot);

   always_ff @(posedge clock) begin
      if (pop) item_ff <= pop_data;
      if (state_ff == ST_COS)
         sin_ff <= sin_neg ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});
      if (state_ff == ST_CAP)
         cos_ff <= cos_neg ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});
      if (state_ff == ST_MUL) begin
         p1_ff <= cos_ff * item_ff.dw;
         p2_ff <= sin_ff * item_ff.dh;
         p3_ff <= sin_ff * item_ff.dw;
         p4_ff <= cos_ff * item_ff.dh;
      end
      if (state_ff == ST_WAIT && div_done) begin
         case (grp)
            2'd0:    nx_ff[k] <= sat20(q_ext - 49'sd65536);
            2'd1:    ny_ff[k] <= sat20(49'sd65536 - q_ext);
            default: begin
               if (k[1]) v_ff[k[0]] <= sat20(q_ext);
               else      u_ff[k[0]] <= sat20(q_ext);
            end
         endcase
      end
   end

   // vertex output
   logic [1:0] cid;
   assign cid                 = corner_of(slot_ff);
   assign rsp_ch.valid        = (state_ff == ST_EMIT);
   assign rsp_ch.ndc_x        = nx_ff[cid];
   assign rsp_ch.ndc_y        = ny_ff[cid];
   assign rsp_ch.vertex_color = item_ff.rgba;
   assign rsp_ch.tex_u        = u_ff[cid[0]];
   assign rsp_ch.tex_v        = v_ff[cid[1]];
   assign rsp_ch.corner_id    = cid;
   assign rsp_ch.last_vertex  = (slot_ff == 3'd5);

endmodule

FILE: design/sprite_quad_vertex_setup.sv
// Rotated sprite quad to NDC triangle list: six vertices per sprite request.
// The twelve divisions share one bit-serial divider (issue, 48 steps, result).
// Six vertices go out at one per cycle while the output is not stalled. The back
// end finishes one sprite before it takes the next; a two-entry queue lets the
// front keep taking requests while the back works.
// Reset (synchronous, active high) empties the pipe and loads default registers.
module sprite_quad_vertex_setup
   import sqvs_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   sqvs_req_if.sink    req_ch,
   sqvs_rsp_if.source  rsp_ch
);

   logic [13:0] vp_w_ff, vp_h_ff;
   logic [14:0] tex_w_ff, tex_h_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_w_ff  <= 14'd1920;
         vp_h_ff  <= 14'd1080;
         tex_w_ff <= 15'd256;
         tex_h_ff <= 15'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_VP_W:  vp_w_ff  <= csr_wdata[13:0];
            REG_VP_H:  vp_h_ff  <= csr_wdata[13:0];
            REG_TEX_W: tex_w_ff <= csr_wdata;
            REG_TEX_H: tex_h_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   logic          push, full, pop, empty;
   sqvs_item_type push_data, pop_data;

   sqvs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   sqvs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   sqvs_back #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .pop      (pop),
      .pop_data (pop_data),
      .vp_w     (vp_w_ff),
      .vp_h     (vp_h_ff),
      .tex_w    (tex_w_ff),
      .tex_h    (tex_h_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: design/sqvs_checker.sv
// Port-level checks on the vertex output of the sprite quad vertex setup.
// Bound to sprite_quad_vertex_setup; depends on nothing else.
module sqvs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_color,
   input logic [1:0]  rsp_corner,
   input logic        rsp_last
);

   // the sixth vertex is always the bottom-right corner
   a_last_is_br: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_corner == 2'd3)
      else $error("last vertex not bottom-right");

   // bottom-right appears only as the sixth vertex
   a_br_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_corner == 2'd3 |-> rsp_last)
      else $error("bottom-right vertex not flagged last");

   // color holds across the vertices of one sprite
   a_color_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> $stable(rsp_color) && rsp_valid)
      else $error("sprite color changed mid-quad");

   // a stalled vertex stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("vertex withdrawn under stall");

endmodule

bind sprite_quad_vertex_setup sqvs_checker u_sqvs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_color  (rsp_ch.vertex_color),
   .rsp_corner (rsp_ch.corner_id),
   .rsp_last   (rsp_ch.last_vertex)
);
